// ===== src/xbi_pkg.sv =====
// Shared widths, register codes, reset values and latency of the xyt bucket index block.
package xbi_pkg;

  // field widths
  localparam int COORD_W = 11;
  localparam int ANGLE_W = 9;
  localparam int BKT_W   = 31;
  localparam int LIM_W   = 10;
  localparam int PIX_W   = 8;
  localparam int DEG_W   = 9;
  localparam int CFG_W   = 10;

  // long division: dividend and divisor widths, one quotient bit per stage
  localparam int DVD_W = 11;
  localparam int DVS_W = 9;

  // angle check and default angle span for the bucket count
  localparam int ANGLE_LIMIT   = 359;
  localparam int MAX_ANGLE_DEF = 359;

  // entry stage, division steps, two multiply stages
  localparam int LATENCY = DVD_W + 3;

  // reset values of the registers
  localparam logic [LIM_W-1:0] LIMIT_X_RST = LIM_W'(511);
  localparam logic [LIM_W-1:0] LIMIT_Y_RST = LIM_W'(511);
  localparam logic [PIX_W-1:0] CELL_PIX_RST = PIX_W'(16);
  localparam logic [DEG_W-1:0] CELL_DEG_RST = DEG_W'(30);

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_LIMIT_X      = 2'd0,
    REG_LIMIT_Y      = 2'd1,
    REG_CELL_PIXELS  = 2'd2,
    REG_CELL_DEGREES = 2'd3
  } reg_idx_t;

endpackage

// ===== src/xyt_bucket_index.sv =====
// Top level: pipelined bucket index of a point in an x, y, angle grid.
//
// One point is taken in every cycle (busy stays low) and its result appears
// on bucket and status, marked by done, once the beat has passed through
// one entry stage with the range checks, eleven long-division stages
// that each settle one quotient bit of all five quotients (x and y cells,
// angle cell, y and angle bucket counts), then two stages with one multiplier
// each. The receiver cannot stall, so results are never held back. Register
// writes through the cfg channel are taken in every cycle and must only be
// made while no point is in flight.
module xyt_bucket_index #(
  parameter int MAX_ANGLE = xbi_pkg::MAX_ANGLE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [xbi_pkg::COORD_W-1:0]     coord_x,
  input  logic [xbi_pkg::COORD_W-1:0]     coord_y,
  input  logic [xbi_pkg::ANGLE_W-1:0]     angle,
  output logic                            done,
  output logic [xbi_pkg::BKT_W-1:0]       bucket,
  output logic                            status,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  xbi_pkg::reg_idx_t               cfg_index,
  input  logic [xbi_pkg::CFG_W-1:0]       cfg_data
);
  import xbi_pkg::*;

  // lanes of the division array
  localparam int NLANE  = 5;
  localparam int L_X    = 0;
  localparam int L_Y    = 1;
  localparam int L_YB   = 2;
  localparam int L_T    = 3;
  localparam int L_TB   = 4;

  localparam int A_W    = 2 * DVD_W;
  localparam int TB_W   = $clog2(MAX_ANGLE + 2);
  localparam int MUL_W  = (A_W + TB_W + 1 > BKT_W) ? A_W + TB_W + 1 : BKT_W;
  localparam logic [DVD_W-1:0] TB_DIVIDEND = DVD_W'(MAX_ANGLE + 1);

  typedef struct packed {
    logic [DVD_W-1:0] num;
    logic [DVS_W-1:0] rem;
    logic [DVD_W-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic                  ok;
    lane_t [NLANE-1:0]     lane;
  } stage_t;

  // configuration registers
  logic [LIM_W-1:0] limit_x;
  logic [LIM_W-1:0] limit_y;
  logic [PIX_W-1:0] cell_pixels;
  logic [DEG_W-1:0] cell_degrees;

  assign cfg_ready = 1'b1;
  // every cycle is open for a new point
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_x      <= LIMIT_X_RST;
      limit_y      <= LIMIT_Y_RST;
      cell_pixels  <= CELL_PIX_RST;
      cell_degrees <= CELL_DEG_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LIMIT_X:      limit_x      <= cfg_data[LIM_W-1:0];
        REG_LIMIT_Y:      limit_y      <= cfg_data[LIM_W-1:0];
        REG_CELL_PIXELS:  cell_pixels  <= cfg_data[PIX_W-1:0];
        REG_CELL_DEGREES: cell_degrees <= cfg_data[DEG_W-1:0];
        default: ;
      endcase
    end
  end

  // one restoring division step: one quotient bit
  function automatic lane_t div_step(lane_t l, logic [DVS_W-1:0] d);
    lane_t            o;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             qbit;
    trial = {l.rem, l.num[DVD_W-1]};
    diff  = trial - {1'b0, d};
    qbit  = (trial >= {1'b0, d});
    o.num = {l.num[DVD_W-2:0], 1'b0};
    o.rem = qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    o.quo = {l.quo[DVD_W-2:0], qbit};
    return o;
  endfunction

  // entry: range checks and dividends
  logic [COORD_W:0] sum_x, dif_x, sum_y, dif_y;
  logic             ok_in;
  stage_t           entry;
  logic [DVS_W-1:0] div_pix, div_deg;

  assign div_pix = {{(DVS_W-PIX_W){1'b0}}, cell_pixels};
  assign div_deg = cell_degrees;

  always_comb begin
    sum_x = {2'b00, limit_x} + {coord_x[COORD_W-1], coord_x};
    dif_x = {2'b00, limit_x} - {coord_x[COORD_W-1], coord_x};
    sum_y = {2'b00, limit_y} + {coord_y[COORD_W-1], coord_y};
    dif_y = {2'b00, limit_y} - {coord_y[COORD_W-1], coord_y};
    ok_in = !sum_x[COORD_W] && !dif_x[COORD_W] && !sum_y[COORD_W] && !dif_y[COORD_W]
            && (angle <= ANGLE_W'(ANGLE_LIMIT))
            && (cell_pixels != '0) && (cell_degrees != '0);
    entry.ok = ok_in;
    for (int i = 0; i < NLANE; i++) begin
      entry.lane[i].rem = '0;
      entry.lane[i].quo = '0;
    end
    entry.lane[L_X].num  = sum_x[DVD_W-1:0];
    entry.lane[L_Y].num  = sum_y[DVD_W-1:0];
    entry.lane[L_YB].num = {limit_y, 1'b1};
    entry.lane[L_T].num  = {{(DVD_W-ANGLE_W){1'b0}}, angle};
    entry.lane[L_TB].num = TB_DIVIDEND;
  end

  // division pipeline
  stage_t stg [0:DVD_W];
  logic   vld [0:DVD_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= DVD_W; s++) begin
        vld[s] <= 1'b0;
      end
    end else begin
      vld[0] <= start && !busy;
      for (int s = 1; s <= DVD_W; s++) begin
        vld[s] <= vld[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    stg[0] <= entry;
    for (int s = 1; s <= DVD_W; s++) begin
      stg[s].ok <= stg[s-1].ok;
      stg[s].lane[L_X]  <= div_step(stg[s-1].lane[L_X],  div_pix);
      stg[s].lane[L_Y]  <= div_step(stg[s-1].lane[L_Y],  div_pix);
      stg[s].lane[L_YB] <= div_step(stg[s-1].lane[L_YB], div_pix);
      stg[s].lane[L_T]  <= div_step(stg[s-1].lane[L_T],  div_deg);
      stg[s].lane[L_TB] <= div_step(stg[s-1].lane[L_TB], div_deg);
    end
  end

  // first multiply: x cell times y count plus y cell, bucket counts rounded up
  lane_t            lx, ly, lyb, lt, ltb;
  logic [DVD_W:0]   yb_full, tb_full;
  logic [A_W-1:0]   a_next;
  logic [TB_W-1:0]  tb_next;

  always_comb begin
    lx      = stg[DVD_W].lane[L_X];
    ly      = stg[DVD_W].lane[L_Y];
    lyb     = stg[DVD_W].lane[L_YB];
    lt      = stg[DVD_W].lane[L_T];
    ltb     = stg[DVD_W].lane[L_TB];
    yb_full = {1'b0, lyb.quo} + {{DVD_W{1'b0}}, |lyb.rem};
    tb_full = {1'b0, ltb.quo} + {{DVD_W{1'b0}}, |ltb.rem};
    a_next  = {{DVD_W{1'b0}}, lx.quo} * {{DVD_W{1'b0}}, yb_full[DVD_W-1:0]}
              + {{DVD_W{1'b0}}, ly.quo};
    tb_next = tb_full[TB_W-1:0];
  end

  logic             m1_vld;
  logic             m1_ok;
  logic [A_W-1:0]   m1_a;
  logic [TB_W-1:0]  m1_tb;
  logic [ANGLE_W-1:0] m1_ti;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
    end else begin
      m1_vld <= vld[DVD_W];
    end
  end

  always_ff @(posedge clk) begin
    m1_ok <= stg[DVD_W].ok;
    m1_a  <= a_next;
    m1_tb <= tb_next;
    m1_ti <= lt.quo[ANGLE_W-1:0];
  end

  // second multiply: times angle count plus angle cell, masked to the index width
  logic [MUL_W-1:0] mul;

  assign mul = MUL_W'(m1_a) * MUL_W'(m1_tb) + MUL_W'(m1_ti);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    bucket <= m1_ok ? mul[BKT_W-1:0] : '0;
    status <= !m1_ok;
  end

endmodule

// ===== src/xbi_checker.sv =====
// Port-level checker for the xyt bucket index block, bound to its top level.
module xbi_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic [xbi_pkg::COORD_W-1:0]     coord_x,
  input logic [xbi_pkg::COORD_W-1:0]     coord_y,
  input logic [xbi_pkg::ANGLE_W-1:0]     angle,
  input logic                            done,
  input logic [xbi_pkg::BKT_W-1:0]       bucket,
  input logic                            status,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input xbi_pkg::reg_idx_t               cfg_index,
  input logic [xbi_pkg::CFG_W-1:0]       cfg_data
);
  import xbi_pkg::*;

  // every accepted beat yields its result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted point gave no result after the pipeline latency");

  // no result without a beat that far back
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching input beat");

  // an out-of-range result carries index zero
  a_zero_idx: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (bucket == '0))
    else $error("out-of-range result with non-zero index");

  // an angle above the limit must come out flagged
  a_angle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (angle > ANGLE_W'(ANGLE_LIMIT))) |-> ##LATENCY (done && status))
    else $error("angle above limit not flagged");

  // the most negative x lies outside any limit
  a_min_x: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (coord_x == {1'b1, {(COORD_W-1){1'b0}}}))
      |-> ##LATENCY (done && status))
    else $error("most negative x not flagged");

endmodule

bind xyt_bucket_index xbi_checker u_xbi_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench of the xyt bucket index block: directed and random points.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import xbi_pkg::*;

  localparam int DRAIN_LIMIT  = LATENCY * 20;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_POINTS = 200;

  typedef struct {
    logic [BKT_W-1:0] bucket;
    logic             status;
  } bucket_result_t;

  // Scoreboard: own copy of the registers, predicted results in beat order
  class bucket_checker;
    logic [LIM_W-1:0] lim_x = LIMIT_X_RST;
    logic [LIM_W-1:0] lim_y = LIMIT_Y_RST;
    logic [PIX_W-1:0] pix   = CELL_PIX_RST;
    logic [DEG_W-1:0] deg   = CELL_DEG_RST;
    bucket_result_t   expected_buckets[$];
    int               errors = 0;
    int               n_ok   = 0;
    int               n_oor  = 0;

    function void write_reg(reg_idx_t idx, logic [CFG_W-1:0] d);
      case (idx)
        REG_LIMIT_X:      lim_x = d[LIM_W-1:0];
        REG_LIMIT_Y:      lim_y = d[LIM_W-1:0];
        REG_CELL_PIXELS:  pix   = d[PIX_W-1:0];
        REG_CELL_DEGREES: deg   = d[DEG_W-1:0];
        default: ;
      endcase
    endfunction

    // Bucket index of one accepted point under the current registers
    function void note_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [ANGLE_W-1:0] t);
      longint         sx, sy, lx, ly, px, dg, ybk, tbk, idx;
      bit             ok;
      bucket_result_t r;
      sx = $signed(x);
      sy = $signed(y);
      lx = lim_x;
      ly = lim_y;
      px = pix;
      dg = deg;
      ok = sx >= -lx && sx <= lx && sy >= -ly && sy <= ly && t <= ANGLE_LIMIT &&
           px != 0 && dg != 0;
      if (!ok) begin
        r.bucket = '0;
        r.status = 1'b1;
        n_oor++;
      end else begin
        // a width above the angle span collapses to one angle bucket
        ybk = (2 * ly + 1 + px - 1) / px;
        tbk = (MAX_ANGLE_DEF + 1 + dg - 1) / dg;
        idx = ((lx + sx) / px) * ybk * tbk + ((ly + sy) / px) * tbk + longint'(t) / dg;
        r.bucket = idx[BKT_W-1:0];
        r.status = 1'b0;
        n_ok++;
      end
      expected_buckets.push_back(r);
    endfunction

    function void check_result(logic [BKT_W-1:0] bkt, logic st);
      bucket_result_t e;
      if (expected_buckets.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual bucket %0d status %0d",
                 $time, bkt, st);
        return;
      end
      e = expected_buckets.pop_front();
      if (bkt !== e.bucket) begin
        errors++;
        $display("%0t: bucket mismatch, expected %0d, actual %0d", $time, e.bucket, bkt);
      end
      if (st !== e.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, e.status, st);
      end
    endfunction

    function int pending();
      return expected_buckets.size();
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 busy;
  logic [COORD_W-1:0]   coord_x   = '0;
  logic [COORD_W-1:0]   coord_y   = '0;
  logic [ANGLE_W-1:0]   angle     = '0;
  logic                 done;
  logic [BKT_W-1:0]     bucket;
  logic                 status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  reg_idx_t             cfg_index = REG_LIMIT_X;
  logic [CFG_W-1:0]     cfg_data  = '0;

  bucket_checker sb = new();
  int            cur_lx = LIMIT_X_RST;
  int            cur_ly = LIMIT_Y_RST;
  int            n_settings = 1;

  xyt_bucket_index dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .angle     (angle),
    .done      (done),
    .bucket    (bucket),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor: register writes, accepted point beats and result strobes
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(bucket, status);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (start && !busy) sb.note_point(coord_x, coord_y, angle);
    end
  end

  // Present one point and hold it until the beat is taken
  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [ANGLE_W-1:0] t);
    start   <= 1'b1;
    coord_x <= x;
    coord_y <= y;
    angle   <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random gap after a beat: none when quiet, else mostly none, some short, a few long
  task automatic idle_gap(input bit quiet);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    gap = (quiet || r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    if (start) start <= 1'b0;
    // one edge first, so the monitor has noted the last beat before counting
    @(posedge clk);
    waited++;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  task automatic cfg_beat(input reg_idx_t idx, input logic [CFG_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write all four registers back to back; only called with nothing in flight
  task automatic write_config(input int lx, input int ly, input int px, input int dg);
    cfg_beat(REG_LIMIT_X, CFG_W'(lx));
    cfg_beat(REG_LIMIT_Y, CFG_W'(ly));
    cfg_beat(REG_CELL_PIXELS, CFG_W'(px));
    cfg_beat(REG_CELL_DEGREES, CFG_W'(dg));
    cfg_valid <= 1'b0;
    cur_lx = lx;
    cur_ly = ly;
    n_settings++;
    @(posedge clk);
  endtask

  // Pick one coordinate: mostly inside the limit, some on the boundary, some anywhere
  function automatic logic [COORD_W-1:0] pick_coord(input int lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return COORD_W'($urandom_range(0, 2047));
    if (r < 20) return COORD_W'($urandom_range(0, 1) ? lim : -lim);
    return COORD_W'(int'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  task automatic random_point(input bit quiet);
    logic [ANGLE_W-1:0] t;
    int                 r;
    r = $urandom_range(0, 99);
    if (r < 10)      t = ANGLE_W'($urandom_range(ANGLE_LIMIT + 1, 511));
    else if (r < 15) t = $urandom_range(0, 1) ? ANGLE_W'(ANGLE_LIMIT) : '0;
    else             t = ANGLE_W'($urandom_range(0, ANGLE_LIMIT));
    send_point(pick_coord(cur_lx), pick_coord(cur_ly), t);
    idle_gap(quiet);
  endtask

  task automatic directed_point(input int x, input int y, input int t);
    send_point(COORD_W'(x), COORD_W'(y), ANGLE_W'(t));
    idle_gap(1'b0);
  endtask

  function automatic int pick_limit();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 1023;
      default: return $urandom_range(0, 1023);
    endcase
  endfunction

  // Main sequence
  initial begin
    int  px;
    int  dg;
    bit  quiet;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: limit edges, coordinate extremes, angle edges
    directed_point(0, 0, 0);
    directed_point(-511, -511, 0);
    directed_point(511, 511, 359);
    directed_point(-512, 0, 10);
    directed_point(512, 0, 10);
    directed_point(0, -512, 10);
    directed_point(0, 512, 10);
    directed_point(-1024, -1024, 0);
    directed_point(1023, 1023, 0);
    directed_point(5, 5, 360);
    directed_point(5, 5, 511);
    directed_point(100, -100, 200);
    drain_results();

    // widest grid: largest index
    write_config(1023, 1023, 1, 1);
    directed_point(1023, 1023, 359);
    directed_point(-1023, -1023, 0);
    directed_point(-1024, 0, 0);
    drain_results();

    // zero limits, widest cells
    write_config(0, 0, 255, 360);
    directed_point(0, 0, 359);
    directed_point(1, 0, 0);
    directed_point(0, -1, 0);
    drain_results();

    // zero bucket widths always flag out of range
    write_config(511, 200, 0, 0);
    directed_point(0, 0, 0);
    directed_point(10, 10, 100);
    drain_results();

    // angle width beyond the span, pixel width from masked upper data bits
    write_config(300, 300, 10'h3FF, 511);
    directed_point(-300, 300, 359);
    directed_point(17, -42, 123);
    drain_results();

    // random phases, each under fresh register settings
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 9))
        0:       px = $urandom_range(0, 1023);
        1:       px = $urandom_range(1, 4);
        default: px = $urandom_range(1, 255);
      endcase
      case ($urandom_range(0, 9))
        0:       dg = $urandom_range(0, 1023);
        1:       dg = $urandom_range(361, 511);
        default: dg = $urandom_range(1, 360);
      endcase
      write_config(pick_limit(), pick_limit(), px, dg);
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_POINTS; i++) random_point(quiet);
      drain_results();
    end

    repeat (LATENCY + 4) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: results missing, expected %0d more, actual 0", $time, sb.pending());
    end
    $display("Covered %0d points: %0d in range, %0d out of range, under %0d register settings",
             sb.n_ok + sb.n_oor, sb.n_ok, sb.n_oor, n_settings);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
src/xbi_pkg.sv
src/xyt_bucket_index.sv
src/xbi_checker.sv
dv/tb_top.sv
